// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the stable sorted-list priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int PRI_W    = 4;
   localparam int ID_W     = 32;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   // datapath operations chosen by the controller
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_EMPTY  = 2'd2;
   localparam logic [1:0] OP_REFUSE = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       execute;
      logic [1:0] op;
   } spq_cmd_type;

   typedef struct packed {
      logic req_kind;
      logic empty;
      logic full;
   } spq_stat_type;

endpackage

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// controller: takes a transaction, picks the operation, runs the result handshake
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  spq_stat_type stat,
   output spq_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      if (stat.req_kind == REQ_INSERT) begin
         cmd.op = stat.full ? OP_REFUSE : OP_INSERT;
      end else begin
         cmd.op = stat.empty ? OP_EMPTY : OP_REMOVE;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// sorted slot array with compare-and-shift cells, entry count, result register
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]             req_tuser,
   input  spq_cmd_type            cmd,
   output spq_stat_type           stat,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   logic [PRI_W-1:0] slot_pri_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]  slot_id_ff  [QUEUE_DEPTH];
   logic [CW-1:0]    count_ff, count_in;

   logic             kind_ff;
   logic [PRI_W-1:0] pri_ff;
   logic [ID_W-1:0]  id_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [PRI_W-1:0]    rpri_ff, rpri_in;
   logic [OCC_W-1:0]    occ_ff;

   logic [QUEUE_DEPTH-1:0] gt;
   logic [QUEUE_DEPTH-1:0] move;

   assign stat.req_kind = kind_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == FULL_COUNT);

   // captured request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser[0];
         pri_ff  <= req_tdata[PRI_W-1:0];
         id_ff   <= req_tdata[PRI_W+ID_W-1:PRI_W];
      end
   end

   // per-slot insert decision
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt[i]   = (CW'(i) < count_ff) && (slot_pri_ff[i] > pri_ff);
         move[i] = gt[i] || (CW'(i) == count_ff);
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            if (cmd.op == OP_INSERT && move[i]) begin
               if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                  slot_pri_ff[i] <= slot_pri_ff[(i > 0) ? i - 1 : 0];
                  slot_id_ff[i]  <= slot_id_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  slot_pri_ff[i] <= pri_ff;
                  slot_id_ff[i]  <= id_ff;
               end
            end else if (cmd.op == OP_REMOVE && i < QUEUE_DEPTH - 1) begin
               slot_pri_ff[i] <= slot_pri_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
               slot_id_ff[i]  <= slot_id_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_EMPTY;
      rid_in    = '0;
      rpri_in   = '0;
      case (cmd.op)
         OP_INSERT: begin
            count_in  = count_ff + CW'(1);
            status_in = STATUS_INSERTED;
         end
         OP_REMOVE: begin
            count_in  = count_ff - CW'(1);
            status_in = STATUS_REMOVED;
            rid_in    = slot_id_ff[0];
            rpri_in   = slot_pri_ff[0];
         end
         OP_REFUSE: status_in = STATUS_FULL;
         default:   status_in = STATUS_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         rid_ff    <= rid_in;
         rpri_ff   <= rpri_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {{(RSP_TDATA_W - ID_W - PRI_W - OCC_W){1'b0}}, occ_ff, rpri_ff, rid_ff};

endmodule

// ===== src/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue kept as a sorted list, equal priorities leave in
// arrival order
// ----------------------------------------------------------------------------
// channel | direction | tdata (low bit up)                     | tuser
// req     | in        | entry_priority[3:0], entry_id[35:4]    | req_type[0]
// rsp     | out       | removed_id[31:0], removed_priority     | status[1:0]
//         |           | [35:32], occupancy[40:36]              |
//
// each transaction is first captured, then runs as one compare-and-shift pass
// of all slot cells in parallel that also loads the result register
// a new request is taken while a result still waits on rsp_tready
// a stalled result holds the update pass until the result register frees
// reset clears the entry count and both handshakes, slot contents are kept
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // entry_priority, entry_id
   input  logic [0:0]             req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // removed_id, removed_priority, occupancy
   output logic [STATUS_W-1:0]    rsp_tuser   // status
);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the priority queue result channel
// ----------------------------------------------------------------------------
module spq_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

   logic [OCC_W-1:0] occ;
   assign occ = rsp_tdata[ID_W+PRI_W+OCC_W-1:ID_W+PRI_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // only a removal carries head fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_REMOVED |-> rsp_tdata[ID_W+PRI_W-1:0] == '0)
      else $error("head fields set on a non-removal result");

   // empty and full reports match the occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> occ == '0)
      else $error("empty status with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> occ == FULL_OCC)
      else $error("full status without full occupancy");

   // a new result follows an accepted request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a request");

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives insert and remove transactions into the stable priority queue and
// checks every result against a sorted-list mirror of the queue, covering the
// empty and full cases, ties in priority and long stalls on both channels
// ----------------------------------------------------------------------------
module tb_top
   import spq_pkg::*;
();

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     removed_id;
      logic [PRI_W-1:0]    removed_pri;
      logic [OCC_W-1:0]    occupancy;
   } queue_result_type;

   class queue_scoreboard;
      logic [PRI_W-1:0] mirror_pri [DEPTH];
      logic [ID_W-1:0]  mirror_id  [DEPTH];
      int               held = 0;
      int               error_count = 0;
      queue_result_type pending_results [$];

      function void note_request(logic kind, logic [PRI_W-1:0] pri, logic [ID_W-1:0] id);
         queue_result_type r;
         int               pos;
         int               i;
         r = '0;
         if (kind == REQ_INSERT) begin
            if (held >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < held && mirror_pri[pos] <= pri) pos++;
               for (i = held; i > pos; i--) begin
                  mirror_pri[i] = mirror_pri[i-1];
                  mirror_id[i]  = mirror_id[i-1];
               end
               mirror_pri[pos] = pri;
               mirror_id[pos]  = id;
               held++;
               r.status = STATUS_INSERTED;
            end
         end else begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.removed_id  = mirror_id[0];
               r.removed_pri = mirror_pri[0];
               for (i = 1; i < held; i++) begin
                  mirror_pri[i-1] = mirror_pri[i];
                  mirror_id[i-1]  = mirror_id[i];
               end
               held--;
               r.status = STATUS_REMOVED;
            end
         end
         r.occupancy = held[OCC_W-1:0];
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: status %0d tdata %h", tuser, tdata);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         if (tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, tuser);
            error_count++;
         end
         if (tdata[31:0] !== want.removed_id) begin
            $error("removed_id: expected %h, actual %h", want.removed_id, tdata[31:0]);
            error_count++;
         end
         if (tdata[35:32] !== want.removed_pri) begin
            $error("removed_priority: expected %0d, actual %0d", want.removed_pri,
                   tdata[35:32]);
            error_count++;
         end
         if (tdata[40:36] !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, tdata[40:36]);
            error_count++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   queue_scoreboard sb = new;
   int req_idle_pct = 8;
   int rsp_idle_pct = 53;
   int results_seen = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   stable_priority_queue #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver, with one long hold-off so the queue backs up into the input
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!long_hold_done && results_seen == 40) begin
         rsp_tready     <= 1'b0;
         hold_left      <= 60;
         long_hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser);
         results_seen <= results_seen + 1;
      end
   end

   task automatic send_request(input logic kind, input logic [PRI_W-1:0] pri,
                               input logic [ID_W-1:0] id);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, id, pri};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, pri, id);
   endtask

   initial begin
      int               n;
      int               k;
      int               bias;
      int               seg_left;
      logic             kind;
      logic [PRI_W-1:0] pri;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, extremes and ties
      send_request(REQ_REMOVE, 4'hF, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 4'hF, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 4'h0, 32'h0000_0000);
      send_request(REQ_INSERT, 4'hF, 32'h0000_0001);
      send_request(REQ_REMOVE, 4'h0, 32'h0000_0000);
      send_request(REQ_REMOVE, 4'h5, 32'h1234_5678);
      send_request(REQ_REMOVE, 4'hA, 32'h8765_4321);
      send_request(REQ_REMOVE, 4'h0, 32'h0000_0000);

      // fill to the limit, then one refused insert
      for (k = 0; k < DEPTH; k++) begin
         case (k % 3)
            0: pri = 4'h0;
            1: pri = 4'hF;
            default: pri = 4'h7;
         endcase
         send_request(REQ_INSERT, pri, 32'hA5A5_0000 + k);
      end
      send_request(REQ_INSERT, 4'h0, 32'h5A5A_5A5A);

      seg_left = 0;
      bias = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            req_idle_pct = 53;
            rsp_idle_pct <= 8;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(40, 8);
            case ($urandom_range(2))
               0: bias = 85;
               1: bias = 50;
               default: bias = 15;
            endcase
         end
         seg_left--;
         kind = ($urandom_range(99) < bias) ? REQ_INSERT : REQ_REMOVE;
         pri  = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom);
         send_request(kind, pri, $urandom);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue.sv
src/spq_checker.sv
dv/tb_top.sv
